@@ src/sbk_pkg.sv @@
// shared types and codes for the sort and batch block
`default_nettype none
package sbk_pkg;

  localparam int unsigned MaterialW = 32;
  localparam int unsigned MeshW     = 32;
  localparam int unsigned PayloadW  = 64;
  // sort key: material in the top bits, then meshlet flag, then mesh id
  localparam int unsigned KeyW      = MaterialW + 1 + MeshW;
  localparam int unsigned BatchW    = 6;
  localparam int unsigned BCountW   = 7;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_FINALISE = 2'd1;
  localparam logic [1:0] OP_CLEAR    = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_FINALISED = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [MaterialW-1:0] material_id;
    logic                 is_meshlet;
    logic [MeshW-1:0]     mesh_id;
    logic [PayloadW-1:0]  instance_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PayloadW-1:0]  out_instance;
    logic [MaterialW-1:0] out_material;
    logic                 out_meshlet;
    logic [MeshW-1:0]     out_mesh;
    logic [BatchW-1:0]    batch_index;
    logic [BatchW-1:0]    batch_first;
    logic                 batch_end;
    logic [BCountW-1:0]   batch_count;
    logic                 last;
  } out_item_t;

endpackage
`default_nettype wire

@@ src/sbk_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module sbk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ src/sort_and_batch_by_key.sv @@
// top level of the sort and batch block: entry store, insertion sorter, batch emitter
//
// Entries are added one item per cycle (opcode add) into a 65-bit key ram and
// a 64-bit payload ram; a slot-order ram is written by the sort. All three are
// MAX_ENTRIES deep. An add or a clear gives no result unless the add is rejected.
// A finalise runs a stable insertion sort over the order ram, comparing keys read
// back from the key ram: each placement of entry i reads its key, then for each
// earlier entry reads its slot from the order ram and that slot's key, and shifts
// it up while the new key is smaller; it stops at the front or at the first
// earlier entry whose key is not larger. The sorted list is then walked with a
// one-entry look-ahead so that each result knows whether it closes its batch.
// No new item is taken while a finalise is sorting or emitting, or while a
// status result waits for the output register. Opcode 3 is ignored.
`default_nettype none
module sort_and_batch_by_key #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sbk_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sbk_pkg::out_item_t      out_item_o
);

  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KeyW = sbk_pkg::KeyW;
  localparam int unsigned PayW = sbk_pkg::PayloadW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STATUS,
    ST_SORT_LOAD,
    ST_SORT_CUR,
    ST_SORT_ORD,
    ST_SORT_PSLOT,
    ST_SORT_CMP,
    ST_EMIT_ORD,
    ST_EMIT_KEY,
    ST_EMIT_CAP,
    ST_EMIT_OUT
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;        // entries held
  logic                fin_q;          // finalised flag
  logic [1:0]          status_q;       // pending status code
  logic [CntW-1:0]     i_q;            // entry being inserted
  logic [AW-1:0]       j_q;            // insertion position
  logic [AW-1:0]       prev_slot_q;    // slot read from order[j-1]
  logic [KeyW-1:0]     cur_key_q;      // key being inserted, later key of current result
  logic [PayW-1:0]     cur_pay_q;
  logic [KeyW-1:0]     nxt_key_q;      // look-ahead entry
  logic [PayW-1:0]     nxt_pay_q;
  logic [AW-1:0]       pos_q;          // sorted position of current result
  logic                first_q;        // first fetch of the emit walk
  logic [AW-1:0]       batch_q;
  logic [AW-1:0]       bfirst_q;
  logic                out_valid_q;
  sbk_pkg::out_item_t  out_q;

  // ram ports
  logic                key_we, key_re;
  logic [AW-1:0]       key_raddr;
  logic [KeyW-1:0]     key_wdata, key_rdata;
  logic                pay_re;
  logic [PayW-1:0]     pay_rdata;
  logic                ord_we, ord_re;
  logic [AW-1:0]       ord_waddr, ord_raddr, ord_wdata, ord_rdata;

  logic                in_acc;
  logic                out_free;
  logic                add_ok;
  logic                key_less;
  logic                is_last;
  logic                closes;
  logic                near_end;
  logic [CntW-1:0]     i_next;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a new entry goes in only before finalise and while there is room
  assign add_ok    = in_acc && (in_item_i.opcode == sbk_pkg::OP_ADD) && !fin_q
                     && (count_q != CntW'(MAX_ENTRIES));
  assign key_we    = add_ok;
  assign key_wdata = {in_item_i.material_id, in_item_i.is_meshlet, in_item_i.mesh_id};

  // sort compare: key ram holds key of the slot found at order[j-1]
  assign key_less = (cur_key_q < key_rdata);
  assign i_next   = i_q + CntW'(1);

  // emit look-ahead bookkeeping
  assign is_last  = ((CntW'(pos_q) + CntW'(1)) == count_q);
  assign near_end = ((CntW'(pos_q) + CntW'(2)) == count_q);
  assign closes   = is_last || (cur_key_q != nxt_key_q);

  // ram address and write control
  always_comb begin
    key_re    = 1'b0;
    key_raddr = '0;
    pay_re    = 1'b0;
    ord_we    = 1'b0;
    ord_waddr = j_q;
    ord_wdata = i_q[AW-1:0];
    ord_re    = 1'b0;
    ord_raddr = j_q - AW'(1);
    case (state_q)
      ST_SORT_LOAD: begin
        key_re    = 1'b1;
        key_raddr = i_q[AW-1:0];
      end
      ST_SORT_ORD: begin
        if (j_q == '0) begin
          ord_we = 1'b1;
        end else begin
          ord_re = 1'b1;
        end
      end
      ST_SORT_PSLOT: begin
        key_re    = 1'b1;
        key_raddr = ord_rdata;
      end
      ST_SORT_CMP: begin
        ord_we = 1'b1;
        if (key_less) begin
          ord_wdata = prev_slot_q;
        end
      end
      ST_EMIT_ORD: begin
        ord_re    = 1'b1;
        ord_raddr = first_q ? pos_q : (pos_q + AW'(1));
      end
      ST_EMIT_KEY: begin
        key_re    = 1'b1;
        pay_re    = 1'b1;
        key_raddr = ord_rdata;
      end
      default: begin
      end
    endcase
  end

  sbk_ram #(
    .Width (KeyW),
    .Depth (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  sbk_ram #(
    .Width (PayW),
    .Depth (MAX_ENTRIES)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_item_i.instance_data),
    .re_i    (pay_re),
    .raddr_i (key_raddr),
    .rdata_o (pay_rdata)
  );

  sbk_ram #(
    .Width (AW),
    .Depth (MAX_ENTRIES)
  ) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      fin_q       <= 1'b0;
      status_q    <= sbk_pkg::STATUS_OK;
      i_q         <= '0;
      j_q         <= '0;
      prev_slot_q <= '0;
      cur_key_q   <= '0;
      cur_pay_q   <= '0;
      nxt_key_q   <= '0;
      nxt_pay_q   <= '0;
      pos_q       <= '0;
      first_q     <= 1'b0;
      batch_q     <= '0;
      bfirst_q    <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_item_i.opcode)
              sbk_pkg::OP_ADD: begin
                if (fin_q) begin
                  status_q <= sbk_pkg::STATUS_FINALISED;
                  state_q  <= ST_STATUS;
                end else if (count_q == CntW'(MAX_ENTRIES)) begin
                  status_q <= sbk_pkg::STATUS_FULL;
                  state_q  <= ST_STATUS;
                end else begin
                  count_q <= count_q + CntW'(1);
                end
              end
              sbk_pkg::OP_FINALISE: begin
                if (fin_q) begin
                  status_q <= sbk_pkg::STATUS_FINALISED;
                  state_q  <= ST_STATUS;
                end else begin
                  fin_q <= 1'b1;
                  if (count_q == '0) begin
                    status_q <= sbk_pkg::STATUS_EMPTY;
                    state_q  <= ST_STATUS;
                  end else begin
                    i_q     <= '0;
                    state_q <= ST_SORT_LOAD;
                  end
                end
              end
              sbk_pkg::OP_CLEAR: begin
                count_q <= '0;
                fin_q   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_STATUS: begin
          // status result: all payload fields zero, last set
          if (out_free) begin
            out_q        <= '0;
            out_q.status <= status_q;
            out_q.last   <= 1'b1;
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_SORT_LOAD: begin
          state_q <= ST_SORT_CUR;
        end
        ST_SORT_CUR: begin
          cur_key_q <= key_rdata;
          j_q       <= i_q[AW-1:0];
          state_q   <= ST_SORT_ORD;
        end
        ST_SORT_ORD: begin
          if (j_q == '0) begin
            // reached the front: entry i placed
            i_q <= i_next;
            if (i_next == count_q) begin
              state_q <= ST_EMIT_ORD;
            end else begin
              state_q <= ST_SORT_LOAD;
            end
          end else begin
            state_q <= ST_SORT_PSLOT;
          end
        end
        ST_SORT_PSLOT: begin
          prev_slot_q <= ord_rdata;
          state_q     <= ST_SORT_CMP;
        end
        ST_SORT_CMP: begin
          if (key_less) begin
            // shift the earlier entry up and keep looking
            j_q     <= j_q - AW'(1);
            state_q <= ST_SORT_ORD;
          end else begin
            // equal keys stop here, which keeps arrival order
            i_q <= i_next;
            if (i_next == count_q) begin
              state_q <= ST_EMIT_ORD;
            end else begin
              state_q <= ST_SORT_LOAD;
            end
          end
        end
        ST_EMIT_ORD: begin
          state_q <= ST_EMIT_KEY;
        end
        ST_EMIT_KEY: begin
          state_q <= ST_EMIT_CAP;
        end
        ST_EMIT_CAP: begin
          if (first_q) begin
            cur_key_q <= key_rdata;
            cur_pay_q <= pay_rdata;
            first_q   <= 1'b0;
            if (is_last) begin
              state_q <= ST_EMIT_OUT;
            end else begin
              state_q <= ST_EMIT_ORD;
            end
          end else begin
            nxt_key_q <= key_rdata;
            nxt_pay_q <= pay_rdata;
            state_q   <= ST_EMIT_OUT;
          end
        end
        ST_EMIT_OUT: begin
          if (out_free) begin
            out_q.status       <= sbk_pkg::STATUS_OK;
            out_q.out_instance <= cur_pay_q;
            out_q.out_material <= cur_key_q[KeyW-1 -: sbk_pkg::MaterialW];
            out_q.out_meshlet  <= cur_key_q[sbk_pkg::MeshW];
            out_q.out_mesh     <= cur_key_q[sbk_pkg::MeshW-1:0];
            out_q.batch_index  <= sbk_pkg::BatchW'(batch_q);
            out_q.batch_first  <= sbk_pkg::BatchW'(bfirst_q);
            out_q.batch_end    <= closes;
            out_q.batch_count  <= closes
                ? sbk_pkg::BCountW'(CntW'(pos_q) - CntW'(bfirst_q) + CntW'(1))
                : '0;
            out_q.last         <= is_last;
            out_valid_q        <= 1'b1;
            if (closes) begin
              batch_q  <= batch_q + AW'(1);
              bfirst_q <= pos_q + AW'(1);
            end
            cur_key_q <= nxt_key_q;
            cur_pay_q <= nxt_pay_q;
            pos_q     <= pos_q + AW'(1);
            if (is_last) begin
              state_q <= ST_IDLE;
            end else if (near_end) begin
              state_q <= ST_EMIT_OUT;
            end else begin
              state_q <= ST_EMIT_ORD;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // emit walk starts from sorted position zero
      if ((state_q == ST_SORT_ORD && j_q == '0 && i_next == count_q)
          || (state_q == ST_SORT_CMP && !key_less && i_next == count_q)) begin
        pos_q    <= '0;
        first_q  <= 1'b1;
        batch_q  <= '0;
        bfirst_q <= '0;
      end
    end
  end

endmodule
`default_nettype wire
